### sv/microwire_eeprom_command_master_assert.svh
`ifndef MICROWIRE_EEPROM_COMMAND_MASTER_ASSERT_SVH
`define MICROWIRE_EEPROM_COMMAND_MASTER_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MWE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwe assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define MWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwe assertion failed");

`endif

### sv/mwe_pkg.sv
package mwe_pkg;

    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_ERASE = 3'd2;
    localparam logic [2:0] CMD_WREN  = 3'd3;
    localparam logic [2:0] CMD_WRDIS = 3'd4;

    localparam logic [1:0] REG_TICKS_PER_HALF_BIT = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_POLL     = 2'd1;
    localparam logic [1:0] REG_BUSY_POLL_LIMIT    = 2'd2;
    localparam logic [1:0] REG_READY_POLL_LIMIT   = 2'd3;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SELECT = 4'd1;
    localparam logic [3:0] PH_CLK_LO = 4'd2;
    localparam logic [3:0] PH_CLK_HI = 4'd3;
    localparam logic [3:0] PH_TAIL   = 4'd4;
    localparam logic [3:0] PH_DESEL  = 4'd5;
    localparam logic [3:0] PH_BUSY   = 4'd6;
    localparam logic [3:0] PH_READY  = 4'd7;
    localparam logic [3:0] PH_END    = 4'd8;

    typedef struct packed {
        logic [7:0]  ticks_per_half_bit;
        logic [15:0] ticks_per_poll;
        logic [15:0] busy_poll_limit;
        logic [15:0] ready_poll_limit;
    } mwe_cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] poll_count;
        logic [15:0] tick_count;
        logic        needs_polling;
    } mwe_ctrl_t;

    typedef struct packed {
        logic device_select;
        logic serial_clock;
        logic serial_data;
        logic busy;
        logic done;
        logic timed_out;
    } mwe_result_t;

endpackage

### sv/mwe_step.sv
module mwe_step #(
    parameter int ADDRESS_BITS = 6,
    localparam int CMD_BITS = ADDRESS_BITS + 19,
    localparam int POS_W = $clog2(CMD_BITS)
) (
    input  mwe_pkg::mwe_cfg_t    cfg,
    input  mwe_pkg::mwe_ctrl_t   ctrl,
    input  logic [CMD_BITS-1:0]  command_shift,
    input  logic [POS_W-1:0]     bit_position,
    input  logic [2:0]           command,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic [15:0]          write_data,
    input  logic                 data_out_pin,
    output mwe_pkg::mwe_ctrl_t   ctrl_next,
    output logic [CMD_BITS-1:0]  command_shift_next,
    output logic [POS_W-1:0]     bit_position_next,
    output mwe_pkg::mwe_result_t result
);

    logic                start;
    mwe_pkg::mwe_ctrl_t  eff_ctrl;
    logic [CMD_BITS-1:0] eff_shift;
    logic [POS_W-1:0]    eff_pos;
    logic [15:0]         half_len;
    logic [15:0]         poll_len;
    logic [15:0]         tick_len;
    logic [16:0]         tick_inc;
    logic                wrap;
    logic [15:0]         tick_after;
    logic                cur_bit;
    logic                want;
    logic [15:0]         limit;

    assign start = (ctrl.phase == mwe_pkg::PH_IDLE)
                   && ((command == mwe_pkg::CMD_WRITE) || (command == mwe_pkg::CMD_ERASE)
                   || (command == mwe_pkg::CMD_WREN) || (command == mwe_pkg::CMD_WRDIS));

    always_comb
    begin
        eff_ctrl  = ctrl;
        eff_shift = command_shift;
        eff_pos   = bit_position;
        if (start)
        begin
            priority if (command == mwe_pkg::CMD_WRITE)
            begin
                eff_shift = {3'b101, address, write_data};
                eff_pos   = POS_W'(ADDRESS_BITS + 18);
            end
            else if (command == mwe_pkg::CMD_ERASE)
            begin
                eff_shift = {16'd0, 3'b111, address};
                eff_pos   = POS_W'(ADDRESS_BITS + 2);
            end
            else if (command == mwe_pkg::CMD_WREN)
            begin
                eff_shift = {16'd0, 3'b100, 2'b11, {(ADDRESS_BITS - 2){1'b0}}};
                eff_pos   = POS_W'(ADDRESS_BITS + 2);
            end
            else
            begin
                eff_shift = {16'd0, 3'b100, {ADDRESS_BITS{1'b0}}};
                eff_pos   = POS_W'(ADDRESS_BITS + 2);
            end
            eff_ctrl.needs_polling = (command == mwe_pkg::CMD_WRITE)
                                     || (command == mwe_pkg::CMD_ERASE);
            eff_ctrl.poll_count = 16'd0;
            eff_ctrl.tick_count = 16'd0;
            eff_ctrl.phase      = mwe_pkg::PH_SELECT;
        end
    end

    assign half_len = (cfg.ticks_per_half_bit == 8'd0) ? 16'd1 : {8'd0, cfg.ticks_per_half_bit};
    assign poll_len = (cfg.ticks_per_poll == 16'd0) ? 16'd1 : cfg.ticks_per_poll;
    assign tick_len = ((eff_ctrl.phase == mwe_pkg::PH_BUSY)
                      || (eff_ctrl.phase == mwe_pkg::PH_READY)) ? poll_len : half_len;
    assign tick_inc   = {1'b0, eff_ctrl.tick_count} + 17'd1;
    assign wrap       = tick_inc >= {1'b0, tick_len};
    assign tick_after = wrap ? 16'd0 : tick_inc[15:0];
    assign cur_bit    = eff_shift[eff_pos];
    assign want       = (eff_ctrl.phase == mwe_pkg::PH_READY);
    assign limit      = (eff_ctrl.phase == mwe_pkg::PH_BUSY) ? cfg.busy_poll_limit
                                                             : cfg.ready_poll_limit;

    always_comb
    begin
        ctrl_next          = eff_ctrl;
        command_shift_next = eff_shift;
        bit_position_next  = eff_pos;
        result             = '0;
        result.busy        = (eff_ctrl.phase != mwe_pkg::PH_IDLE);
        unique case (eff_ctrl.phase)
            mwe_pkg::PH_IDLE:
            begin
            end
            mwe_pkg::PH_SELECT:
            begin
                result.device_select = 1'b1;
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    ctrl_next.phase = mwe_pkg::PH_CLK_LO;
                end
            end
            mwe_pkg::PH_CLK_LO:
            begin
                result.device_select = 1'b1;
                result.serial_data   = cur_bit;
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    ctrl_next.phase = mwe_pkg::PH_CLK_HI;
                end
            end
            mwe_pkg::PH_CLK_HI:
            begin
                result.device_select = 1'b1;
                result.serial_clock  = 1'b1;
                result.serial_data   = cur_bit;
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    if (eff_pos == '0)
                    begin
                        ctrl_next.phase = mwe_pkg::PH_TAIL;
                    end
                    else
                    begin
                        bit_position_next = eff_pos - POS_W'(1);
                        ctrl_next.phase   = mwe_pkg::PH_CLK_LO;
                    end
                end
            end
            mwe_pkg::PH_TAIL:
            begin
                result.device_select = 1'b1;
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    ctrl_next.phase = mwe_pkg::PH_DESEL;
                end
            end
            mwe_pkg::PH_DESEL:
            begin
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    if (eff_ctrl.needs_polling)
                    begin
                        ctrl_next.poll_count = 16'd0;
                        ctrl_next.phase      = mwe_pkg::PH_BUSY;
                    end
                    else
                    begin
                        result.done     = 1'b1;
                        ctrl_next.phase = mwe_pkg::PH_IDLE;
                    end
                end
            end
            mwe_pkg::PH_BUSY, mwe_pkg::PH_READY:
            begin
                result.device_select = 1'b1;
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    if (data_out_pin == want)
                    begin
                        ctrl_next.poll_count = 16'd0;
                        ctrl_next.phase = (eff_ctrl.phase == mwe_pkg::PH_BUSY)
                                          ? mwe_pkg::PH_READY : mwe_pkg::PH_END;
                    end
                    else if (eff_ctrl.poll_count >= limit)
                    begin
                        result.done          = 1'b1;
                        result.timed_out     = 1'b1;
                        ctrl_next.poll_count = 16'd0;
                        ctrl_next.phase      = mwe_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ctrl_next.poll_count = eff_ctrl.poll_count + 16'd1;
                    end
                end
            end
            mwe_pkg::PH_END:
            begin
                ctrl_next.tick_count = tick_after;
                if (wrap)
                begin
                    result.done     = 1'b1;
                    ctrl_next.phase = mwe_pkg::PH_IDLE;
                end
            end
            default:
            begin
                result.busy          = 1'b0;
                ctrl_next.tick_count = 16'd0;
                ctrl_next.phase      = mwe_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

### sv/microwire_eeprom_command_master.sv
// Microwire EEPROM command master, advanced by one timing tick per input word.
// Input channel (in_valid, in_stall, command, address, write_data, data_out_pin):
// each accepted word is one tick; a command code of 1 to 4 starts write, erase, write
// enable or write disable when the master is idle and is ignored otherwise.
// Output channel (out_valid, out_stall, pin levels and status): exactly one
// result word per accepted input word, in order, carrying chip select, clock,
// data, busy, done and timeout for that tick.
// An accepted word's result goes to the result register, or to the skid register
// when the output stalls; one word is taken every cycle while in_stall is low, and
// the sequencer logic between the state registers and the result register is combinational.
// The output register is backed by one skid register, so an input word is
// still accepted in the cycle the receiver first stalls; in_stall rises only
// when both are full and falls once the receiver takes a word.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge and must happen only while the master is idle.
// Reset clears the sequencer to idle, empties the output side and restores the
// timing registers to 1, 10, 1500 and 15000.
module microwire_eeprom_command_master #(
    parameter int ADDRESS_BITS = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [mwe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              command,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic [15:0]             write_data,
    input  logic                    data_out_pin,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    device_select,
    output logic                    serial_clock,
    output logic                    serial_data,
    output logic                    busy_res,
    output logic                    done_res,
    output logic                    timed_out
);

    `include "microwire_eeprom_command_master_assert.svh"

    localparam int CMD_BITS = ADDRESS_BITS + 19;
    localparam int POS_W = $clog2(CMD_BITS);

    mwe_pkg::mwe_cfg_t    cfg_reg;
    mwe_pkg::mwe_ctrl_t   ctrl_reg;
    mwe_pkg::mwe_ctrl_t   ctrl_next;
    logic [CMD_BITS-1:0]  command_shift_reg;
    logic [CMD_BITS-1:0]  command_shift_next;
    logic [POS_W-1:0]     bit_position_reg;
    logic [POS_W-1:0]     bit_position_next;
    mwe_pkg::mwe_result_t step_result;
    mwe_pkg::mwe_result_t res_reg;
    mwe_pkg::mwe_result_t res_next;
    mwe_pkg::mwe_result_t skid_reg;
    mwe_pkg::mwe_result_t skid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 accept;
    logic                 main_free;

    mwe_step #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_step (
        .cfg               (cfg_reg),
        .ctrl              (ctrl_reg),
        .command_shift     (command_shift_reg),
        .bit_position      (bit_position_reg),
        .command           (command),
        .address           (address),
        .write_data        (write_data),
        .data_out_pin      (data_out_pin),
        .ctrl_next         (ctrl_next),
        .command_shift_next(command_shift_next),
        .bit_position_next (bit_position_next),
        .result            (step_result)
    );

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign main_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_half_bit <= 8'd1;
            cfg_reg.ticks_per_poll     <= 16'd10;
            cfg_reg.busy_poll_limit    <= 16'd1500;
            cfg_reg.ready_poll_limit   <= 16'd15000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mwe_pkg::REG_TICKS_PER_HALF_BIT: cfg_reg.ticks_per_half_bit <= cfg_data[7:0];
                mwe_pkg::REG_TICKS_PER_POLL:     cfg_reg.ticks_per_poll     <= cfg_data;
                mwe_pkg::REG_BUSY_POLL_LIMIT:    cfg_reg.busy_poll_limit    <= cfg_data;
                mwe_pkg::REG_READY_POLL_LIMIT:   cfg_reg.ready_poll_limit   <= cfg_data;
                default:                         cfg_reg.ready_poll_limit   <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase         <= mwe_pkg::PH_IDLE;
            ctrl_reg.poll_count    <= 16'd0;
            ctrl_reg.tick_count    <= 16'd0;
            ctrl_reg.needs_polling <= 1'b0;
            command_shift_reg      <= '0;
            bit_position_reg       <= '0;
        end
        else if (accept)
        begin
            ctrl_reg          <= ctrl_next;
            command_shift_reg <= command_shift_next;
            bit_position_reg  <= bit_position_next;
        end
    end

    always_comb
    begin
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                res_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                res_next       = step_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = step_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign device_select = res_reg.device_select;
    assign serial_clock  = res_reg.serial_clock;
    assign serial_data   = res_reg.serial_data;
    assign busy_res      = res_reg.busy;
    assign done_res      = res_reg.done;
    assign timed_out     = res_reg.timed_out;

    `MWE_ASSERT_IMPLY(a_skid_behind_main, skid_valid_reg, out_valid_reg)
    `MWE_ASSERT_NEXT(a_accept_fills_output, accept && main_free, out_valid_reg)
    `MWE_ASSERT_IMPLY(a_timeout_with_done, out_valid_reg && timed_out, done_res && busy_res)
    `MWE_ASSERT_IMPLY(a_clock_needs_select, out_valid_reg && serial_clock, device_select)

endmodule
